// ===== hdl/ptpd_pkg.sv =====
// ----------------------------------------------------------------------------
// ptpd_pkg
// Shared types and constants for the point transform with perspective divide.
// ----------------------------------------------------------------------------
package ptpd_pkg;

  // fixed point format of coordinates and matrix entries
  localparam int VALUE_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  // configuration port
  localparam int NUM_REGS    = 8;
  localparam int REG_IDX_W   = 3;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 64;
  localparam int SLOT_W      = 32;

  // divider: one quotient bit per step, STEPS_PER_STAGE steps per stage
  localparam int DIV_STEPS       = VALUE_WIDTH - 1;
  localparam int STEPS_PER_STAGE = 4;
  localparam int DIV_STAGES      = (DIV_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  // register map
  typedef enum logic [REG_IDX_W-1:0] {
    REG_ROW1_LO = 3'd0,
    REG_ROW1_HI = 3'd1,
    REG_ROW2_LO = 3'd2,
    REG_ROW2_HI = 3'd3,
    REG_ROW3_LO = 3'd4,
    REG_ROW3_HI = 3'd5,
    REG_ROW4_LO = 3'd6,
    REG_ROW4_HI = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               w_zero;
  } out_word_t;

endpackage

// ===== hdl/point_transform_perspective_divide_core.sv =====
// ----------------------------------------------------------------------------
// point_transform_perspective_divide_core
// Row vector (x, y, z, 1) times a 4x4 fixed point matrix, then x'/w, y'/w, z'/w.
// ----------------------------------------------------------------------------
// pipeline: input, products, sums, divider setup, then the divider stages (Q16.16)
// throughput: one word per cycle unless the output is stalled; the restoring divider is fully pipelined,
//   STEPS_PER_STAGE quotient bits per stage, one lane for each coordinate
// a stalled output word freezes the whole pipeline in place
// reset: synchronous, clears all valid bits and loads the identity matrix
module point_transform_perspective_divide_core
  import ptpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int W  = VALUE_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 3;
  localparam int NW = W + F;
  localparam int DS = DIV_STAGES;

  logic [CFG_DATA_W-1:0] cfg_regs [NUM_REGS];
  logic signed [W-1:0]   m [4][4];
  logic                  advance;

  // pipeline stage registers
  logic                  v1, v2, v3;
  logic signed [W-1:0]   p1 [3];
  logic signed [PW-1:0]  prod [4][3];
  logic signed [W-1:0]   s3 [4];
  logic signed [W-1:0]   sum_c [4];

  // divider stage registers, index 0 is the setup stage
  logic                  dv    [DS+1];
  logic                  wz_r  [DS+1];
  logic [W-1:0]          den_r [DS+1];
  logic [W:0]            rem_r [DS+1][3];
  logic [W-2:0]          nl_r  [DS+1][3];
  logic [W-1:0]          q_r   [DS+1][3];
  logic                  ovf_r [DS+1][3];
  logic                  neg_r [DS+1][3];

  // setup stage values
  logic [W-1:0]          dmag_c;
  logic [NW-1:0]         num_c [3];
  logic [W-1:0]          nmag_c [3];

  logic signed [W-1:0]   res_c [3];

  // flow control: the pipeline moves unless the output word is held
  assign advance   = !(out_valid && out_stall);
  assign in_stall  = !advance;
  assign cfg_ready = 1'b1;

  // configuration registers, identity matrix after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_regs[i] <= '0;
      end
      cfg_regs[REG_ROW1_LO] <= CFG_DATA_W'(1) << F;
      cfg_regs[REG_ROW2_LO] <= CFG_DATA_W'(1) << (F + SLOT_W);
      cfg_regs[REG_ROW3_HI] <= CFG_DATA_W'(1) << F;
      cfg_regs[REG_ROW4_HI] <= CFG_DATA_W'(1) << (F + SLOT_W);
    end else if (cfg_valid && cfg_ready && !cfg_index[CFG_IDX_W-1]) begin
      cfg_regs[cfg_index[REG_IDX_W-1:0]] <= cfg_data;
    end
  end

  // matrix entries, low W bits of each slot taken as signed
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        m[r][c] = signed'(cfg_regs[REG_IDX_W'(r * 2 + c / 2)][(c % 2) * SLOT_W +: W]);
      end
    end
  end

  // column sums: exact add, floor to F fraction bits, saturate
  always_comb begin
    logic signed [SW-1:0] acc;
    logic signed [SW-1:0] sh;
    for (int c = 0; c < 4; c++) begin
      acc = SW'(prod[c][0]) + SW'(prod[c][1]) + SW'(prod[c][2])
          + (SW'(m[3][c]) <<< F);
      sh  = acc >>> F;
      if (&sh[SW-1:W-1] || !(|sh[SW-1:W-1])) begin
        sum_c[c] = sh[W-1:0];
      end else begin
        sum_c[c] = {sh[SW-1], {(W-1){~sh[SW-1]}}};
      end
    end
  end

  // divider setup: magnitudes and numerators; signs and overflow test are registered with it
  always_comb begin
    dmag_c = s3[3][W-1] ? W'(-s3[3]) : W'(s3[3]);
    for (int l = 0; l < 3; l++) begin
      nmag_c[l] = s3[l][W-1] ? W'(-s3[l]) : W'(s3[l]);
      num_c[l]  = {nmag_c[l], {F{1'b0}}};
    end
  end

  // front stages: input, products, sums, divider setup
  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      dv[0] <= 1'b0;
    end else if (advance) begin
      v1    <= in_valid;
      v2    <= v1;
      v3    <= v2;
      dv[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p1[0] <= in_data.in_x[W-1:0];
      p1[1] <= in_data.in_y[W-1:0];
      p1[2] <= in_data.in_z[W-1:0];
      for (int c = 0; c < 4; c++) begin
        for (int i = 0; i < 3; i++) begin
          prod[c][i] <= p1[i] * m[i][c];
        end
        s3[c] <= sum_c[c];
      end
      wz_r[0]  <= (s3[3] == '0);
      den_r[0] <= dmag_c;
      for (int l = 0; l < 3; l++) begin
        rem_r[0][l] <= (W+1)'(num_c[l] >> (W - 1));
        nl_r[0][l]  <= num_c[l][W-2:0];
        q_r[0][l]   <= '0;
        ovf_r[0][l] <= PW'(num_c[l]) >= (PW'(dmag_c) << (W - 1));
        neg_r[0][l] <= s3[l][W-1] != s3[3][W-1];
      end
    end
  end

  // restoring divider stages
  for (genvar k = 0; k < DS; k++) begin : g_div
    logic [W:0]   rem_c [3];
    logic [W-2:0] nl_c  [3];
    logic [W-1:0] q_c   [3];

    always_comb begin
      logic [W:0]   r;
      logic [W-2:0] n;
      logic [W-1:0] q;
      for (int l = 0; l < 3; l++) begin
        r = rem_r[k][l];
        n = nl_r[k][l];
        q = q_r[k][l];
        for (int j = 0; j < STEPS_PER_STAGE; j++) begin
          if (k * STEPS_PER_STAGE + j < DIV_STEPS) begin
            r = {r[W-1:0], n[W-2]};
            n = {n[W-3:0], 1'b0};
            q = {q[W-2:0], 1'b0};
            if (r >= {1'b0, den_r[k]}) begin
              r    = r - {1'b0, den_r[k]};
              q[0] = 1'b1;
            end
          end
        end
        rem_c[l] = r;
        nl_c[l]  = n;
        q_c[l]   = q;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (advance) begin
        dv[k+1] <= dv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        wz_r[k+1]  <= wz_r[k];
        den_r[k+1] <= den_r[k];
        for (int l = 0; l < 3; l++) begin
          rem_r[k+1][l] <= rem_c[l];
          nl_r[k+1][l]  <= nl_c[l];
          q_r[k+1][l]   <= q_c[l];
          ovf_r[k+1][l] <= ovf_r[k][l];
          neg_r[k+1][l] <= neg_r[k][l];
        end
      end
    end
  end

  // sign, saturation and zero w on the result
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (wz_r[DS]) begin
        res_c[l] = '0;
      end else if (ovf_r[DS][l]) begin
        res_c[l] = neg_r[DS][l] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
        res_c[l] = neg_r[DS][l] ? signed'(-q_r[DS][l]) : signed'(q_r[DS][l]);
      end
    end
  end

  assign out_valid       = dv[DS];
  assign out_data.out_x  = 32'(res_c[0]);
  assign out_data.out_y  = 32'(res_c[1]);
  assign out_data.out_z  = 32'(res_c[2]);
  assign out_data.w_zero = wz_r[DS];

endmodule

// ===== hdl/ptpd_checker.sv =====
// ----------------------------------------------------------------------------
// ptpd_checker
// Port level checks on the point transform core, bound to the core module.
// ----------------------------------------------------------------------------
module ptpd_checker
  import ptpd_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input out_word_t             out_data
);

  // held output word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // zero w gives zero coordinates
  a_wzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.w_zero |->
      out_data.out_x == 0 && out_data.out_y == 0 && out_data.out_z == 0)
    else $error("w_zero word carries nonzero coordinates");

  // input backs up only behind a held output word
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held output word");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output word right after reset");

endmodule

bind point_transform_perspective_divide_core ptpd_checker u_ptpd_checker (.*);
